FILE: sv/ac_power_triangle_top_defines.svh
// Assertion macros shared by the AC power triangle checker.
`ifndef AC_POWER_TRIANGLE_TOP_DEFINES_SVH
`define AC_POWER_TRIANGLE_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define ACPT_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ACPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/acpt_pkg.sv
// Types and constants shared by the AC power triangle pipeline.
package acpt_pkg;

   // Apparent power is prod / 100000 = (prod >> 5) / 3125, the last step by reciprocal.
   localparam int          VA_PRESHIFT = 5;
   localparam logic [20:0] VA_RECIP    = 21'd1374389;
   localparam logic [11:0] VA_ODD      = 12'd3125;
   localparam logic [15:0] VA_MAX      = 16'hFFFF;
   localparam logic [14:0] VAR_MAX     = 15'h7FFF;
   localparam logic [6:0]  PF_FULL     = 7'd100;
   localparam logic [6:0]  DVD_SCALE   = 7'd100;
   localparam int          DIV_STEPS   = 7;
   localparam int          SQRT_STEPS  = 16;
   localparam logic [31:0] SQRT_TOP_BIT = 32'h4000_0000;

   typedef struct packed {
      logic [15:0] s;
      logic [16:0] pmag;
      logic        neg;
      logic [21:0] dvd;
   } front_out_type;

   typedef struct packed {
      logic [15:0] s;
      logic [16:0] pmag;
      logic [7:0]  pf;
   } div_out_type;

   typedef struct packed {
      logic [15:0] s;
      logic [7:0]  pf;
      logic [15:0] root;
   } sqrt_out_type;

endpackage

FILE: sv/acpt_front.sv
// Front stages: V*I product, reciprocal division to apparent power, magnitude of P.
module acpt_front
   import acpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [15:0]         voltage_centivolts,
   input  logic [15:0]         current_milliamps,
   input  logic signed [15:0]  active_watts,
   output logic                out_valid,
   output front_out_type       out_data
);

   logic [15:0]   p_raw;
   logic [16:0]   pmag_in;
   logic          a_valid_ff, b_valid_ff, c_valid_ff;
   logic [31:0]   a_prod_ff;
   logic [16:0]   a_pmag_ff, b_pmag_ff;
   logic          a_neg_ff, b_neg_ff;
   logic [47:0]   b_mul_ff;
   logic [26:0]   b_num_ff;
   logic [15:0]   qe;
   logic [27:0]   back;
   logic [27:0]   rem;
   logic [16:0]   s_full;
   front_out_type c_in;
   front_out_type c_ff;

   assign p_raw   = active_watts;
   assign pmag_in = p_raw[15] ? (17'h10000 - {1'b0, p_raw}) : {1'b0, p_raw};

   // The estimate is the true quotient or one below it; one compare fixes it.
   always_comb begin
      qe     = b_mul_ff[47:32];
      back   = 28'({12'b0, qe} * 28'(VA_ODD));
      rem    = {1'b0, b_num_ff} - back;
      s_full = {1'b0, qe} + 17'(rem >= 28'(VA_ODD));
      c_in.s    = (s_full > {1'b0, VA_MAX}) ? VA_MAX : s_full[15:0];
      c_in.pmag = b_pmag_ff;
      c_in.neg  = b_neg_ff;
      c_in.dvd  = 22'({5'b0, b_pmag_ff} * 22'(DVD_SCALE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_prod_ff <= {16'b0, voltage_centivolts} * {16'b0, current_milliamps};
         a_pmag_ff <= pmag_in;
         a_neg_ff  <= p_raw[15];
         b_mul_ff  <= 48'(a_prod_ff[31:VA_PRESHIFT]) * 48'(VA_RECIP);
         b_num_ff  <= a_prod_ff[31:VA_PRESHIFT];
         b_pmag_ff <= a_pmag_ff;
         b_neg_ff  <= a_neg_ff;
         c_ff      <= c_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_ff;

endmodule

FILE: sv/acpt_div.sv
// Pipelined restoring divider for the power factor, one quotient bit a stage.
module acpt_div
   import acpt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  front_out_type in_data,
   output logic          out_valid,
   output div_out_type   out_data
);

   typedef struct packed {
      logic [15:0] s;
      logic [16:0] pmag;
      logic        neg;
      logic        big;
      logic [21:0] rem;
      logic [6:0]  quo;
   } div_stage_type;

   function automatic div_stage_type div_step(div_stage_type x, int b);
      div_stage_type y;
      logic [22:0]   sh;
      y  = x;
      sh = 23'({7'b0, x.s}) << b;
      if ({1'b0, x.rem} >= sh) begin
         y.rem = 22'({1'b0, x.rem} - sh);
         y.quo = x.quo | (7'd1 << b);
      end
      return y;
   endfunction

   div_stage_type             init;
   div_stage_type             st_in [DIV_STEPS];
   div_stage_type             st_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]      vld_ff;
   logic                      out_valid_ff;
   div_out_type               out_in;
   div_out_type               out_ff;
   div_stage_type             last;
   logic [6:0]                mag;

   always_comb begin
      init.s    = in_data.s;
      init.pmag = in_data.pmag;
      init.neg  = in_data.neg;
      // A quotient of 128 or more clamps anyway, so seven bits suffice.
      init.big  = ({1'b0, in_data.dvd} >= {in_data.s, 7'b0});
      init.rem  = in_data.dvd;
      init.quo  = '0;
      st_in[0]  = div_step(init, DIV_STEPS - 1);
      for (int k = 1; k < DIV_STEPS; k++) begin
         st_in[k] = div_step(st_ff[k-1], DIV_STEPS - 1 - k);
      end
   end

   always_comb begin
      last = st_ff[DIV_STEPS-1];
      if (last.s == 16'd0) begin
         mag = 7'd0;
      end else if (last.big || (last.quo > PF_FULL)) begin
         mag = PF_FULL;
      end else begin
         mag = last.quo;
      end
      out_in.s    = last.s;
      out_in.pmag = last.pmag;
      out_in.pf   = last.neg ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[DIV_STEPS-2:0], in_valid};
         out_valid_ff <= vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/acpt_sqrt.sv
// Pipelined floor square root of S*S - P*P, one root bit a stage.
module acpt_sqrt
   import acpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  div_out_type  in_data,
   output logic         out_valid,
   output sqrt_out_type out_data
);

   typedef struct packed {
      logic [15:0] s;
      logic [7:0]  pf;
      logic [31:0] rad;
      logic [31:0] acc;
   } sqrt_stage_type;

   function automatic sqrt_stage_type sq_step(sqrt_stage_type x, logic [31:0] b);
      sqrt_stage_type y;
      logic [31:0]    trial;
      y     = x;
      trial = x.acc + b;
      if (x.rad >= trial) begin
         y.rad = x.rad - trial;
         y.acc = (x.acc >> 1) + b;
      end else begin
         y.acc = x.acc >> 1;
      end
      return y;
   endfunction

   logic                    q0_valid_ff, q1_valid_ff;
   logic [31:0]             q0_s2_ff;
   logic [30:0]             q0_p2_ff;
   logic [15:0]             q0_s_ff;
   logic [7:0]              q0_pf_ff;
   sqrt_stage_type          q1_in;
   sqrt_stage_type          q1_ff;
   sqrt_stage_type          it_in [SQRT_STEPS];
   sqrt_stage_type          it_ff [SQRT_STEPS];
   logic [SQRT_STEPS-1:0]   vld_ff;

   always_comb begin
      q1_in.s   = q0_s_ff;
      q1_in.pf  = q0_pf_ff;
      q1_in.rad = (q0_s2_ff > {1'b0, q0_p2_ff}) ? (q0_s2_ff - {1'b0, q0_p2_ff}) : 32'd0;
      q1_in.acc = '0;
      it_in[0]  = sq_step(q1_ff, SQRT_TOP_BIT);
      for (int k = 1; k < SQRT_STEPS; k++) begin
         it_in[k] = sq_step(it_ff[k-1], SQRT_TOP_BIT >> (2 * k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q0_valid_ff <= 1'b0;
         q1_valid_ff <= 1'b0;
         vld_ff      <= '0;
      end else if (en) begin
         q0_valid_ff <= in_valid;
         q1_valid_ff <= q0_valid_ff;
         vld_ff      <= {vld_ff[SQRT_STEPS-2:0], q1_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q0_s2_ff <= {16'b0, in_data.s} * {16'b0, in_data.s};
         q0_p2_ff <= 31'({14'b0, in_data.pmag} * {14'b0, in_data.pmag});
         q0_s_ff  <= in_data.s;
         q0_pf_ff <= in_data.pf;
         q1_ff    <= q1_in;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            it_ff[k] <= it_in[k];
         end
      end
   end

   assign out_valid     = vld_ff[SQRT_STEPS-1];
   assign out_data.s    = it_ff[SQRT_STEPS-1].s;
   assign out_data.pf   = it_ff[SQRT_STEPS-1].pf;
   assign out_data.root = it_ff[SQRT_STEPS-1].acc[15:0];

endmodule

FILE: sv/ac_power_triangle_top.sv
// Top level of the AC power triangle block: apparent, reactive power and power factor.
//
// Each request carries one RMS sample: voltage in centivolts, current in milliamps and
// signed active power in watts. The response gives apparent power in VA (saturated at
// 65535), reactive power in var (saturated at 32767) and the signed power factor in
// percent, clamped to -100..100 and zero when apparent power is zero.
// Both channels use valid and stall; a transfer happens when valid is high and stall low.
// The block is a 30-stage pipeline: 3 front stages (product, reciprocal multiply and
// correction), 8 divider stages (one power factor quotient bit each plus the clamp),
// 18 square root stages (squares, difference, one root bit each) and the output register.
// One request is taken every cycle as long as the receiver does not stall.
// A stall with a response waiting freezes every stage at once, so req_stall follows
// rsp_stall whenever a response is held; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty and ready in the next cycle.
// There is no state between requests, so results depend only on their own sample.
module ac_power_triangle_top
   import acpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_voltage_centivolts,
   input  logic [15:0]        req_current_milliamps,
   input  logic signed [15:0] req_active_watts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_apparent_va,
   output logic [14:0]        rsp_reactive_var,
   output logic signed [7:0]  rsp_power_factor_pct
);

   logic          en;
   logic          front_valid, div_valid, sqrt_valid;
   front_out_type front_data;
   div_out_type   div_data;
   sqrt_out_type  sqrt_data;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_va_ff;
   logic [14:0]   rsp_var_ff;
   logic [7:0]    rsp_pf_ff;
   logic [14:0]   var_in;

   // The whole pipeline advances unless a finished response is being held.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   acpt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .en                 (en),
      .in_valid           (req_valid),
      .voltage_centivolts (req_voltage_centivolts),
      .current_milliamps  (req_current_milliamps),
      .active_watts       (req_active_watts),
      .out_valid          (front_valid),
      .out_data           (front_data)
   );

   acpt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   acpt_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (sqrt_valid),
      .out_data  (sqrt_data)
   );

   // The root of a 32-bit value can reach 65535, so it is saturated to 15 bits here.
   assign var_in = (sqrt_data.root > {1'b0, VAR_MAX}) ? VAR_MAX : sqrt_data.root[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_va_ff  <= sqrt_data.s;
         rsp_var_ff <= var_in;
         rsp_pf_ff  <= sqrt_data.pf;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_apparent_va      = rsp_va_ff;
   assign rsp_reactive_var     = rsp_var_ff;
   assign rsp_power_factor_pct = rsp_pf_ff;

endmodule

FILE: sv/acpt_checker.sv
// Port-level checks of the AC power triangle block and their bind to the top level.
`include "ac_power_triangle_top_defines.svh"

module acpt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [15:0]       rsp_apparent_va,
   input logic [14:0]       rsp_reactive_var,
   input logic signed [7:0] rsp_power_factor_pct
);

   logic        rsp_held;
   logic [38:0] rsp_payload;
   logic        rsp_zero_va;
   logic        rsp_zero_ok;
   logic        rsp_bounds_ok;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_apparent_va, rsp_reactive_var, rsp_power_factor_pct};
   assign rsp_zero_va = rsp_valid && (rsp_apparent_va == 16'd0);
   assign rsp_zero_ok = (rsp_power_factor_pct == 8'sd0) && (rsp_reactive_var == 15'd0);
   assign rsp_bounds_ok = ({1'b0, rsp_reactive_var} <= rsp_apparent_va) &&
                          (rsp_power_factor_pct >= -8'sd100) &&
                          (rsp_power_factor_pct <= 8'sd100);

   // A held response must not move while the receiver stalls.
   `ACPT_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_payload), "held response changed")

   // Requests are only held back by a stalled receiver.
   `ACPT_ASSERT_ALWAYS(a_req_free, clock, !rsp_stall |-> !req_stall, "request stalled without cause")

   // Zero apparent power gives zero power factor and zero reactive power.
   `ACPT_ASSERT_CLK(a_zero_va, clock, reset, rsp_zero_va |-> rsp_zero_ok, "nonzero result at zero VA")

   // Reactive power never exceeds apparent power and the power factor stays in range.
   `ACPT_ASSERT_CLK(a_triangle, clock, reset, rsp_valid |-> rsp_bounds_ok, "power triangle bounds violated")

endmodule

bind ac_power_triangle_top acpt_checker u_acpt_checker (.*);

FILE: bench/tb_ac_power_triangle_top.sv
// Self-checking testbench for the AC power triangle block with a clocked driver and monitor.
module tb_ac_power_triangle_top
   import acpt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // One RMS measurement sample as carried by a request.
   typedef struct {
      logic [15:0]        voltage;
      logic [15:0]        current;
      logic signed [15:0] watts;
   } sample_type;

   // The three derived quantities carried by a response.
   typedef struct {
      logic [15:0]       apparent;
      logic [14:0]       reactive;
      logic signed [7:0] pf;
   } triangle_type;

   localparam int RANDOM_SAMPLES = 1650;
   // The pipeline is 30 stages deep, so this covers any straggler with margin.
   localparam int DRAIN_CYCLES   = 64;
   localparam int CALM_FIRST     = 600;
   localparam int CALM_LAST      = 900;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [15:0]        req_voltage_centivolts = '0;
   logic [15:0]        req_current_milliamps = '0;
   logic signed [15:0] req_active_watts = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_apparent_va;
   logic [14:0]        rsp_reactive_var;
   logic signed [7:0]  rsp_power_factor_pct;

   sample_type   samples_to_send[$];
   triangle_type triangles_due[$];
   int           samples_total = 0;
   int           samples_taken = 0;
   int           mismatches = 0;

   ac_power_triangle_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_voltage_centivolts(req_voltage_centivolts),
      .req_current_milliamps(req_current_milliamps),
      .req_active_watts     (req_active_watts),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_apparent_va      (rsp_apparent_va),
      .rsp_reactive_var     (rsp_reactive_var),
      .rsp_power_factor_pct (rsp_power_factor_pct)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Floor square root, one result bit at a time from the top down.
   function automatic logic [15:0] floor_sqrt(logic [31:0] radicand);
      logic [15:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = 64'(root | (16'd1 << b));
         if (trial * trial <= 64'(radicand)) begin
            root = trial[15:0];
         end
      end
      return root;
   endfunction

   // Works out the power triangle for one sample.
   function automatic triangle_type power_triangle(sample_type smp);
      logic [31:0]    product;
      logic [31:0]    va;
      logic [16:0]    p_mag;
      logic [31:0]    pct;
      logic [63:0]    s_sq;
      logic [63:0]    p_sq;
      logic [31:0]    q;
      triangle_type   outcome;
      product = 32'(smp.voltage) * 32'(smp.current);
      va = product / 32'd100000;
      if (va > 32'(VA_MAX)) begin
         va = 32'(VA_MAX);
      end
      // The magnitude of the most negative power, 32768, does not fit a signed 16-bit value.
      p_mag = smp.watts[15] ? (17'h10000 - {1'b0, smp.watts}) : {1'b0, smp.watts};
      outcome.apparent = va[15:0];
      outcome.pf = '0;
      if (va != 0) begin
         pct = (32'(p_mag) * 32'd100) / va;
         if (pct > 32'd100) begin
            pct = 32'd100;
         end
         outcome.pf = smp.watts[15] ? -pct[7:0] : pct[7:0];
      end
      s_sq = 64'(va) * 64'(va);
      p_sq = 64'(p_mag) * 64'(p_mag);
      q = '0;
      if (s_sq > p_sq) begin
         q = 32'(floor_sqrt(32'(s_sq - p_sq)));
      end
      if (q > 32'(VAR_MAX)) begin
         q = 32'(VAR_MAX);
      end
      outcome.reactive = q[14:0];
      return outcome;
   endfunction

   function automatic void queue_sample(int v, int c, int w);
      sample_type smp;
      smp.voltage = 16'(v);
      smp.current = 16'(c);
      smp.watts = 16'(w);
      samples_to_send.push_back(smp);
      samples_total++;
   endfunction

   // Idling is switched off for a stretch in the middle of the random part so that
   // the pipeline also runs completely full for a few hundred requests.
   function automatic bit take_a_break();
      if (samples_taken >= CALM_FIRST && samples_taken < CALM_LAST) begin
         return 1'b0;
      end
      return $urandom_range(99) < 16;
   endfunction

   // Request driver. A request is taken at an edge where valid is high and stall is
   // low; the prediction is made right there so the expected responses stay in order.
   // A stalled request keeps its payload until it is taken.
   always @(posedge clock) begin
      sample_type smp;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            smp.voltage = req_voltage_centivolts;
            smp.current = req_current_milliamps;
            smp.watts = req_active_watts;
            triangles_due.push_back(power_triangle(smp));
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (samples_to_send.size() != 0 && !take_a_break()) begin
               smp = samples_to_send.pop_front();
               req_valid <= 1'b1;
               req_voltage_centivolts <= smp.voltage;
               req_current_milliamps <= smp.current;
               req_active_watts <= smp.watts;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. It also stalls the response channel at random, and every
   // response taken is compared field by field with the oldest prediction.
   always @(posedge clock) begin
      triangle_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_a_break();
         if (rsp_valid && !rsp_stall) begin
            if (triangles_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = triangles_due.pop_front();
               if (rsp_apparent_va !== want.apparent) begin
                  $error("apparent_va: expected %0d, got %0d", want.apparent, rsp_apparent_va);
                  mismatches++;
               end
               if (rsp_reactive_var !== want.reactive) begin
                  $error("reactive_var: expected %0d, got %0d",
                         want.reactive, rsp_reactive_var);
                  mismatches++;
               end
               if (rsp_power_factor_pct !== want.pf) begin
                  $error("power_factor_pct: expected %0d, got %0d",
                         want.pf, rsp_power_factor_pct);
                  mismatches++;
               end
            end
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      int kind;
      int v;
      int c;
      int s;
      int m;

      // Directed part. Zero apparent power, with the power factor forced to zero
      // even for the largest active power of either sign.
      queue_sample(0, 0, 0);
      queue_sample(0, 0, -32768);
      queue_sample(0, 65535, 32767);
      queue_sample(65535, 0, -1);
      // A product of 99999 still truncates to zero, 100000 gives exactly 1 VA.
      queue_sample(33333, 3, 7);
      queue_sample(100, 1000, 5);
      queue_sample(100, 1000, -5);
      queue_sample(100, 1000, 1);
      queue_sample(100, 1000, 0);
      // Largest sample: the reactive power saturates when the active power is small.
      queue_sample(65535, 65535, 0);
      queue_sample(65535, 65535, 32767);
      queue_sample(65535, 65535, -32768);
      // Active power equal to apparent power leaves a zero radicand.
      queue_sample(23000, 10000, 2300);
      queue_sample(23000, 10000, -2300);
      // Ordinary lagging load, and truncation of a negative factor toward zero.
      queue_sample(23000, 10000, 1380);
      queue_sample(23000, 10000, -1381);
      // Reactive power just at and just above its saturation point.
      queue_sample(65535, 50000, 0);
      queue_sample(65535, 50001, 0);
      // Most negative active power against a mid apparent power.
      queue_sample(32768, 32768, -32768);
      // Alternating bit patterns on every field.
      queue_sample(16'h5555, 16'hAAAA, 16'h5555);
      queue_sample(16'hAAAA, 16'h5555, -21846);

      // Random part, mostly plausible mains samples with random load.
      for (int i = 0; i < RANDOM_SAMPLES; i++) begin
         kind = $urandom_range(9);
         case (kind)
            0, 1, 2: begin
               queue_sample($urandom_range(65535), $urandom_range(65535),
                            int'($signed(16'($urandom))));
            end
            3, 4, 5, 6: begin
               // Active power somewhere within the apparent power.
               v = $urandom_range(20000, 25000);
               c = $urandom_range(65535);
               s = (v * c) / 100000;
               m = $urandom_range(0, (s > 32767) ? 32767 : s);
               queue_sample(v, c, $urandom_range(1) ? -m : m);
            end
            7: begin
               // Active power right around the apparent power. The full product
               // does not fit a 32-bit signed integer.
               v = $urandom_range(65535);
               c = $urandom_range(65535);
               s = int'((longint'(v) * longint'(c)) / 64'sd100000);
               m = s + $urandom_range(4) - 2;
               m = (m < 0) ? 0 : ((m > 32767) ? 32767 : m);
               queue_sample(v, c, $urandom_range(1) ? -m : m);
            end
            8: begin
               // Tiny samples, where apparent power sits at zero or a few VA.
               queue_sample($urandom_range(1000), $urandom_range(1000),
                            int'($urandom_range(20)) - 10);
            end
            default: begin
               // Heavy samples near the top of both ranges.
               queue_sample($urandom_range(50000, 65535), $urandom_range(50000, 65535),
                            int'($signed(16'($urandom))));
            end
         endcase
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is taken and every response has come back.
      do begin
         @(posedge clock);
      end while (samples_taken != samples_total || triangles_due.size() != 0);
      // Give a stray extra response the chance to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("ac_power_triangle_top verification clean");
      end else begin
         $display("ac_power_triangle_top verification failed");
      end
      $finish;
   end

   // Watchdog in case the block stops handshaking.
   initial begin
      #2ms;
      $display("ac_power_triangle_top verification failed");
      $finish;
   end

endmodule
